// ===== src/cpd_pkg.sv =====
package cpd_pkg;

    localparam int unsigned MulIters = 33;
    localparam int unsigned DivIters = 43;
    localparam int unsigned CntW = 6;

    localparam logic [2:0] OP_MP = 3'd0;
    localparam logic [2:0] OP_MI = 3'd1;
    localparam logic [2:0] OP_MT = 3'd2;
    localparam logic [2:0] OP_DI = 3'd3;
    localparam logic [2:0] OP_DD = 3'd4;
    localparam logic [2:0] OP_DP = 3'd5;

    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_P_GAIN = 2'd1;
    localparam logic [1:0] REG_I_GAIN = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    localparam logic [16:0] ONE_Q = 17'd65536;
    localparam logic [17:0] TWO_Q = 18'd131072;
    localparam logic [21:0] PERIOD_FLOOR = 22'd327680;
    localparam logic [21:0] PERIOD_CEIL = 22'd3932160;
    localparam logic [32:0] SMALL_ERR = 33'd6554;
    localparam logic [31:0] MIN_STEP_MS = 32'd10;
    localparam logic [27:0] RECIP_1000 = 28'd137438954;
    localparam logic [76:0] INT_SAT_LIMIT = 77'd8589934592000;
    localparam logic [42:0] PERIOD_NUM = 43'd128849018880;
    localparam logic [43:0] M_CAP = 44'h800_0000_0000;

    typedef struct packed {
        logic signed [31:0] measurement;
        logic               measurement_ok;
        logic [31:0]        elapsed_ms;
    } cpd_in_t;

    typedef struct packed {
        logic signed [18:0] drive;
        logic [21:0]        pwm_period;
        logic               updated;
    } cpd_out_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       step;
        logic       save;
        logic [2:0] op;
        logic       commit;
        logic       update;
    } cpd_cmd_t;

    typedef struct packed {
        logic upd_req;
    } cpd_stat_t;

endpackage

// ===== src/clamped_pid_drive_with_pwm_period.sv =====
// An item that does not update (bad reading or 10 ms or less) passes from acceptance through
// S_FIN to the output register; an updating item first runs four 33-step shift-add
// multiplications (one scales by the reciprocal of 1000) and two 43-step restoring divisions.
// One item is processed at a time: the next item is accepted only after the last one has
// gone to the output register, also while that result still waits there unread.
// Reset clears the settings, the integral and the held drive and sets the held period to 60 s.
module clamped_pid_drive_with_pwm_period (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              meas_valid,
    output logic              meas_ready,
    input  cpd_pkg::cpd_in_t  meas_item,
    output logic              res_valid,
    input  logic              res_ready,
    output cpd_pkg::cpd_out_t res_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cpd_pkg::*;

    cpd_cmd_t  cmd;
    cpd_stat_t stat;
    logic      cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    cpd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    cpd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (meas_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (paddr[3:2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .cmd       (cmd),
        .stat      (stat),
        .res_item  (res_item)
    );

endmodule

// ===== src/cpd_ctrl.sv =====
module cpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             meas_valid,
    output logic             meas_ready,
    output logic             res_valid,
    input  logic             res_ready,
    input  cpd_pkg::cpd_stat_t stat,
    output cpd_pkg::cpd_cmd_t  cmd
);
    import cpd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN = 2'd1;
    localparam logic [1:0] S_FIN = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            upd_reg, upd_next;
    logic            res_valid_reg, res_valid_next;
    logic [CntW-1:0] last_cnt;

    assign last_cnt = (op_reg <= OP_MT || op_reg == OP_DI) ? CntW'(MulIters + 1)
                                                           : CntW'(DivIters + 1);
    assign meas_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        upd_next = upd_reg;
        res_valid_next = res_valid_reg;
        cmd = '0;
        cmd.op = op_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (meas_valid)
                begin
                    cmd.load = 1'b1;
                    upd_next = stat.upd_req;
                    op_next = OP_MP;
                    cnt_next = '0;
                    state_next = stat.upd_req ? S_RUN : S_FIN;
                end
            end
            S_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.init = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (cnt_reg == last_cnt)
                begin
                    cmd.save = 1'b1;
                    cnt_next = '0;
                    if (op_reg == OP_DP)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        op_next = op_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.commit = 1'b1;
                    cmd.update = upd_reg;
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_MP;
            cnt_reg <= '0;
            upd_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
            upd_reg <= upd_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== src/cpd_dpath.sv =====
module cpd_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  cpd_pkg::cpd_in_t   in_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    output logic [31:0]        cfg_rdata,
    input  cpd_pkg::cpd_cmd_t  cmd,
    output cpd_pkg::cpd_stat_t stat,
    output cpd_pkg::cpd_out_t  res_item
);
    import cpd_pkg::*;

    logic signed [31:0] setpoint_reg, p_gain_reg, i_gain_reg;
    logic               invert_reg;
    logic signed [31:0] meas_reg;
    logic [31:0]        ms_reg;

    logic [43:0] mul_a_reg;
    logic [76:0] prod_reg;
    logic [42:0] div_n_reg;
    logic [32:0] div_d_reg, rem_reg;

    logic [16:0] prop_mag_reg, diff_mag_reg;
    logic [43:0] mcap_reg;
    logic        isat_reg;
    logic [26:0] tprod_reg;
    logic [17:0] inc_mag_reg;
    logic [21:0] period_reg;

    logic signed [17:0] integ_reg;
    logic signed [18:0] held_drive_reg;
    logic [21:0]        held_period_reg;

    logic signed [32:0] err_w;
    logic               eneg, pneg, ineg;
    logic [32:0]        emag;
    logic [31:0]        pmag, imag;
    logic [44:0]        msum;
    logic [33:0]        dr, drn;
    logic               dge;

    logic signed [19:0] prop_s, diff_s, inc_s, acc_sum, y_sum, y_out;
    logic signed [17:0] acc_new;

    assign stat.upd_req = in_item.measurement_ok && (in_item.elapsed_ms > MIN_STEP_MS);

    assign err_w = {setpoint_reg[31], setpoint_reg} - {meas_reg[31], meas_reg};
    assign eneg = err_w[32];
    assign emag = eneg ? (33'd0 - err_w) : err_w;
    assign pneg = p_gain_reg[31];
    assign ineg = i_gain_reg[31];
    assign pmag = pneg ? (32'd0 - p_gain_reg) : p_gain_reg;
    assign imag = ineg ? (32'd0 - i_gain_reg) : i_gain_reg;

    assign msum = {1'b0, prod_reg[76:33]} + (prod_reg[0] ? {1'b0, mul_a_reg} : 45'd0);
    assign dr = {rem_reg, div_n_reg[42]};
    assign dge = (dr >= {1'b0, div_d_reg});
    assign drn = dge ? (dr - {1'b0, div_d_reg}) : dr;

    always_comb
    begin
        prop_s = (eneg ^ pneg) ? -$signed({3'b0, prop_mag_reg}) : $signed({3'b0, prop_mag_reg});
        diff_s = eneg ? -$signed({3'b0, diff_mag_reg}) : $signed({3'b0, diff_mag_reg});
        inc_s = (eneg ^ ineg) ? -$signed({2'b0, inc_mag_reg}) : $signed({2'b0, inc_mag_reg});
        acc_sum = 20'(integ_reg) + inc_s;
        if (acc_sum > $signed({3'b0, ONE_Q}))
        begin
            acc_new = $signed({1'b0, ONE_Q});
        end
        else if (acc_sum < -$signed({3'b0, ONE_Q}))
        begin
            acc_new = -$signed({1'b0, ONE_Q});
        end
        else
        begin
            acc_new = acc_sum[17:0];
        end
        y_sum = prop_s + 20'(acc_new) + diff_s;
        y_out = invert_reg ? -y_sum : y_sum;
    end

    always_comb
    begin
        case (cfg_addr)
            REG_SETPOINT: cfg_rdata = setpoint_reg;
            REG_P_GAIN:   cfg_rdata = p_gain_reg;
            REG_I_GAIN:   cfg_rdata = i_gain_reg;
            REG_INVERT:   cfg_rdata = {31'd0, invert_reg};
            default:      cfg_rdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            p_gain_reg <= '0;
            i_gain_reg <= '0;
            invert_reg <= 1'b0;
            integ_reg <= '0;
            held_drive_reg <= '0;
            held_period_reg <= PERIOD_CEIL;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SETPOINT: setpoint_reg <= cfg_wdata;
                    REG_P_GAIN:   p_gain_reg <= cfg_wdata;
                    REG_I_GAIN:   i_gain_reg <= cfg_wdata;
                    REG_INVERT:   invert_reg <= cfg_wdata[0];
                    default:      invert_reg <= invert_reg;
                endcase
            end
            if (cmd.commit && cmd.update)
            begin
                integ_reg <= acc_new;
                held_drive_reg <= y_out[18:0];
                held_period_reg <= period_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= in_item.measurement;
            ms_reg <= in_item.elapsed_ms;
        end
        if (cmd.init)
        begin
            rem_reg <= '0;
            case (cmd.op)
                OP_MP:
                begin
                    mul_a_reg <= {12'd0, pmag};
                    prod_reg <= {44'd0, emag};
                end
                OP_MI:
                begin
                    mul_a_reg <= {12'd0, imag};
                    prod_reg <= {44'd0, emag};
                end
                OP_MT:
                begin
                    mul_a_reg <= mcap_reg;
                    prod_reg <= {45'd0, ms_reg};
                end
                OP_DI:
                begin
                    mul_a_reg <= {16'd0, RECIP_1000};
                    prod_reg <= {50'd0, tprod_reg};
                end
                OP_DD:
                begin
                    div_n_reg <= ({10'd0, emag} << 10) - ({10'd0, emag} << 4)
                                 - ({10'd0, emag} << 3);
                    div_d_reg <= {1'b0, ms_reg};
                end
                OP_DP:
                begin
                    div_n_reg <= PERIOD_NUM;
                    div_d_reg <= emag;
                end
                default:
                begin
                    div_d_reg <= div_d_reg;
                end
            endcase
        end
        if (cmd.step)
        begin
            if (cmd.op <= OP_MT || cmd.op == OP_DI)
            begin
                prod_reg <= {msum, prod_reg[32:1]};
            end
            else
            begin
                rem_reg <= drn[32:0];
                div_n_reg <= {div_n_reg[41:0], dge};
            end
        end
        if (cmd.save)
        begin
            case (cmd.op)
                OP_MP:
                begin
                    prop_mag_reg <= (prod_reg[76:16] > 61'(ONE_Q)) ? ONE_Q : prod_reg[32:16];
                end
                OP_MI:
                begin
                    mcap_reg <= (prod_reg[76:43] != '0) ? M_CAP : {1'b0, prod_reg[42:0]};
                end
                OP_MT:
                begin
                    isat_reg <= (prod_reg >= INT_SAT_LIMIT);
                    tprod_reg <= prod_reg[42:16];
                end
                OP_DI:
                begin
                    inc_mag_reg <= (isat_reg || prod_reg[76:37] > 40'(TWO_Q)) ? TWO_Q
                                   : prod_reg[54:37];
                end
                OP_DD:
                begin
                    diff_mag_reg <= (div_n_reg > 43'(ONE_Q)) ? ONE_Q : div_n_reg[16:0];
                end
                OP_DP:
                begin
                    if (emag < SMALL_ERR)
                    begin
                        period_reg <= PERIOD_CEIL;
                    end
                    else if (div_n_reg < 43'(PERIOD_FLOOR))
                    begin
                        period_reg <= PERIOD_FLOOR;
                    end
                    else if (div_n_reg > 43'(PERIOD_CEIL))
                    begin
                        period_reg <= PERIOD_CEIL;
                    end
                    else
                    begin
                        period_reg <= div_n_reg[21:0];
                    end
                end
                default:
                begin
                    period_reg <= period_reg;
                end
            endcase
        end
        if (cmd.commit)
        begin
            if (cmd.update)
            begin
                res_item.drive <= y_out[18:0];
                res_item.pwm_period <= period_reg;
                res_item.updated <= 1'b1;
            end
            else
            begin
                res_item.drive <= held_drive_reg;
                res_item.pwm_period <= held_period_reg;
                res_item.updated <= 1'b0;
            end
        end
    end

endmodule

// ===== src/cpd_checker.sv =====
module cpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              meas_valid,
    input logic              meas_ready,
    input logic              res_valid,
    input logic              res_ready,
    input cpd_pkg::cpd_out_t res_item
);
    import cpd_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready |=> !meas_ready)
        else $error("input taken while busy");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ($signed(res_item.drive) <= 19'sd196608)
                   && ($signed(res_item.drive) >= -19'sd196608))
        else $error("drive out of range");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.pwm_period >= PERIOD_FLOOR)
                   && (res_item.pwm_period <= PERIOD_CEIL))
        else $error("period out of range");

endmodule

bind clamped_pid_drive_with_pwm_period cpd_checker u_cpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
);
